### src/ppmd_pkg.sv
// ppmd_pkg: shared types and constants for the PPM pulse train decoder.
// Used by ppmd_edge, ppmd_probe and ppm_pulse_train_decoder_core.
package ppmd_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    localparam int TIME_W   = 32;
    localparam int SEL_W    = 8;
    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 4;
    localparam int TMO_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int S_TDATA_W = 40;   // time_us + channel_select, byte aligned
    localparam int M_TDATA_W = 24;   // result fields, byte aligned

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Reset contents of every channel slot
    localparam logic [VALUE_W-1:0] STORE_INIT = 16'd1500;

    localparam logic [VALUE_W-1:0] SYNC_GAP_RST   = 16'd3000;
    localparam logic [VALUE_W-1:0] PULSE_MIN_RST  = 16'd700;
    localparam logic [VALUE_W-1:0] PULSE_MAX_RST  = 16'd2200;
    localparam logic [VALUE_W-1:0] CLAMP_LOW_RST  = 16'd1000;
    localparam logic [VALUE_W-1:0] CLAMP_HIGH_RST = 16'd2000;
    localparam logic [VALUE_W-1:0] CENTER_RST     = 16'd1500;
    localparam logic [TMO_W-1:0]   LINK_TMO_RST   = 24'd500000;

    typedef enum logic {
        OP_EDGE  = 1'b0,
        OP_PROBE = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_GAP   = 3'd0,
        CFG_PULSE_MIN  = 3'd1,
        CFG_PULSE_MAX  = 3'd2,
        CFG_CLAMP_LOW  = 3'd3,
        CFG_CLAMP_HIGH = 3'd4,
        CFG_CENTER     = 3'd5,
        CFG_LINK_TMO   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [VALUE_W-1:0] sync_gap;
        logic [VALUE_W-1:0] pulse_min;
        logic [VALUE_W-1:0] pulse_max;
        logic [VALUE_W-1:0] clamp_low;
        logic [VALUE_W-1:0] clamp_high;
        logic [VALUE_W-1:0] center;
        logic [TMO_W-1:0]   link_tmo;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] channel_value;
        logic [COUNT_W-1:0] channel_count;
        logic               frame_ready;
        logic               link_up;
    } result_t;

endpackage

### src/ppmd_edge.sv
// ppmd_edge: edge timing, interval classification, channel store and frame status.
// Depends on ppmd_pkg.
module ppmd_edge #(
    parameter int MAX_CHANNELS = ppmd_pkg::MAX_CHANNELS_DEF,
    parameter int CNT_W = $clog2(MAX_CHANNELS + 1),
    parameter int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ppmd_pkg::cfg_t               cfg,
    input  logic                         edge_en,
    input  logic                         probe_en,
    input  logic [ppmd_pkg::TIME_W-1:0]  now,
    input  logic [IDX_W-1:0]             rd_index,
    output logic [ppmd_pkg::VALUE_W-1:0] rd_data,
    output logic [CNT_W-1:0]             frame_channels,
    output logic                         frame_pending,
    output logic [ppmd_pkg::TIME_W-1:0]  frame_end_time
);
    import ppmd_pkg::*;

    logic [TIME_W-1:0]  prev_edge_reg;
    logic               edge_seen_reg;
    logic [VALUE_W-1:0] store_reg [MAX_CHANNELS];
    logic [CNT_W-1:0]   capture_idx_reg;
    logic [CNT_W-1:0]   frame_channels_reg;
    logic [TIME_W-1:0]  frame_end_reg;
    logic               frame_pending_reg;

    logic [TIME_W-1:0]  gap;
    logic               is_sync;
    logic               in_window;
    logic               store_free;
    logic               timed_edge;

    assign timed_edge = edge_en && edge_seen_reg;
    assign gap        = now - prev_edge_reg;
    assign is_sync    = gap > TIME_W'(cfg.sync_gap);
    assign in_window  = (gap >= TIME_W'(cfg.pulse_min)) && (gap <= TIME_W'(cfg.pulse_max));
    assign store_free = capture_idx_reg < CNT_W'(MAX_CHANNELS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_edge_reg      <= '0;
            edge_seen_reg      <= 1'b0;
            capture_idx_reg    <= '0;
            frame_channels_reg <= '0;
            frame_end_reg      <= '0;
            frame_pending_reg  <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                store_reg[i] <= STORE_INIT;
            end
        end
        else
        begin
            if (edge_en)
            begin
                prev_edge_reg <= now;
                edge_seen_reg <= 1'b1;
            end
            if (timed_edge)
            begin
                if (is_sync)
                begin
                    // latch the frame only if it carried channels
                    if (capture_idx_reg != '0)
                    begin
                        frame_channels_reg <= capture_idx_reg;
                        frame_end_reg      <= now;
                        frame_pending_reg  <= 1'b1;
                    end
                    capture_idx_reg <= '0;
                end
                else if (in_window && store_free)
                begin
                    store_reg[capture_idx_reg[IDX_W-1:0]] <= gap[VALUE_W-1:0];
                    capture_idx_reg <= capture_idx_reg + 1'b1;
                end
            end
            else if (probe_en)
            begin
                frame_pending_reg <= 1'b0;
            end
        end
    end

    assign rd_data        = store_reg[rd_index];
    assign frame_channels = frame_channels_reg;
    assign frame_pending  = frame_pending_reg;
    assign frame_end_time = frame_end_reg;

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        capture_idx_reg <= CNT_W'(MAX_CHANNELS))
        else $error("capture index past store depth");

    a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
        frame_pending_reg |-> frame_channels_reg != '0)
        else $error("frame pending with empty frame");

    a_probe_clears: assert property (@(posedge clk) disable iff (!rst_n)
        probe_en |=> !frame_pending_reg)
        else $error("probe did not clear frame flag");

endmodule

### src/ppmd_probe.sv
// ppmd_probe: builds the probe result: clamped channel read, saturated count, link test.
// Depends on ppmd_pkg.
module ppmd_probe #(
    parameter int MAX_CHANNELS = ppmd_pkg::MAX_CHANNELS_DEF,
    parameter int CNT_W = $clog2(MAX_CHANNELS + 1)
) (
    input  ppmd_pkg::cfg_t               cfg,
    input  logic [ppmd_pkg::TIME_W-1:0]  now,
    input  logic [ppmd_pkg::SEL_W-1:0]   sel,
    input  logic [ppmd_pkg::VALUE_W-1:0] rd_data,
    input  logic [CNT_W-1:0]             frame_channels,
    input  logic                         frame_pending,
    input  logic [ppmd_pkg::TIME_W-1:0]  frame_end_time,
    output ppmd_pkg::result_t            result
);
    import ppmd_pkg::*;

    localparam int EW = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [EW-1:0]      cnt_ext;
    logic [VALUE_W-1:0] clamped;
    logic [TIME_W-1:0]  age;
    logic               sel_ok;

    assign sel_ok  = sel < SEL_W'(MAX_CHANNELS);
    assign cnt_ext = EW'(frame_channels);
    assign age     = now - frame_end_time;

    always_comb
    begin
        // low limit wins over high when the limits are inverted
        priority if (rd_data < cfg.clamp_low)
            clamped = cfg.clamp_low;
        else if (rd_data > cfg.clamp_high)
            clamped = cfg.clamp_high;
        else
            clamped = rd_data;
    end

    always_comb
    begin
        result.channel_value = sel_ok ? clamped : cfg.center;
        result.channel_count = (cnt_ext > EW'(COUNT_MAX)) ? COUNT_MAX
                                                          : cnt_ext[COUNT_W-1:0];
        result.frame_ready   = frame_pending;
        result.link_up       = age < TIME_W'(cfg.link_tmo);
    end

endmodule

### src/ppm_pulse_train_decoder_core.sv
// PPM pulse train decoder top level: input register, config bank, result register.
// A probe passes the input register, then the result register, before it shows on m_*.
// Throughput: one transaction per cycle; an edge in the input register always retires,
// a probe waits while the result register is full and not taken, holding off s_* behind it.
// Reset: asynchronous active-low; config takes reset values, channel slots read 1500.
// Depends on ppmd_pkg, ppmd_edge, ppmd_probe.
module ppm_pulse_train_decoder_core #(
    parameter int MAX_CHANNELS = ppmd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [ppmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppmd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ppmd_pkg::S_TDATA_W-1:0]   s_tdata,  // time_us[31:0], channel_select[39:32]
    input  logic                             s_tuser,  // opcode[0]
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ppmd_pkg::M_TDATA_W-1:0]   m_tdata   // channel_value[15:0],
                                                       // channel_count[19:16],
                                                       // frame_ready[20], link_up[21], 0
);
    import ppmd_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    cfg_t              cfg_reg;

    logic              in_valid_reg;
    opcode_t           in_op_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic [SEL_W-1:0]  in_sel_reg;

    logic              out_valid_reg;
    result_t           out_reg;

    logic              out_free;
    logic              advance;
    logic              edge_en;
    logic              probe_en;

    logic [VALUE_W-1:0] rd_data;
    logic [CNT_W-1:0]   frame_channels;
    logic               frame_pending;
    logic [TIME_W-1:0]  frame_end_time;
    result_t            result;

    // configuration bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_gap   <= SYNC_GAP_RST;
            cfg_reg.pulse_min  <= PULSE_MIN_RST;
            cfg_reg.pulse_max  <= PULSE_MAX_RST;
            cfg_reg.clamp_low  <= CLAMP_LOW_RST;
            cfg_reg.clamp_high <= CLAMP_HIGH_RST;
            cfg_reg.center     <= CENTER_RST;
            cfg_reg.link_tmo   <= LINK_TMO_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SYNC_GAP:   cfg_reg.sync_gap   <= cfg_wr_data[VALUE_W-1:0];
                CFG_PULSE_MIN:  cfg_reg.pulse_min  <= cfg_wr_data[VALUE_W-1:0];
                CFG_PULSE_MAX:  cfg_reg.pulse_max  <= cfg_wr_data[VALUE_W-1:0];
                CFG_CLAMP_LOW:  cfg_reg.clamp_low  <= cfg_wr_data[VALUE_W-1:0];
                CFG_CLAMP_HIGH: cfg_reg.clamp_high <= cfg_wr_data[VALUE_W-1:0];
                CFG_CENTER:     cfg_reg.center     <= cfg_wr_data[VALUE_W-1:0];
                CFG_LINK_TMO:   cfg_reg.link_tmo   <= cfg_wr_data[TMO_W-1:0];
                default:        ;
            endcase
        end
    end

    // edges always retire; a probe waits for room in the result register
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && ((in_op_reg == OP_EDGE) || out_free);
    assign edge_en  = advance && (in_op_reg == OP_EDGE);
    assign probe_en = advance && (in_op_reg == OP_PROBE);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= opcode_t'(s_tuser);
            in_time_reg <= s_tdata[TIME_W-1:0];
            in_sel_reg  <= s_tdata[TIME_W +: SEL_W];
        end
    end

    ppmd_edge #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CNT_W        (CNT_W),
        .IDX_W        (IDX_W)
    ) u_edge (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .edge_en        (edge_en),
        .probe_en       (probe_en),
        .now            (in_time_reg),
        .rd_index       (in_sel_reg[IDX_W-1:0]),
        .rd_data        (rd_data),
        .frame_channels (frame_channels),
        .frame_pending  (frame_pending),
        .frame_end_time (frame_end_time)
    );

    ppmd_probe #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CNT_W        (CNT_W)
    ) u_probe (
        .cfg            (cfg_reg),
        .now            (in_time_reg),
        .sel            (in_sel_reg),
        .rd_data        (rd_data),
        .frame_channels (frame_channels),
        .frame_pending  (frame_pending),
        .frame_end_time (frame_end_time),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= probe_en;
    end

    always_ff @(posedge clk)
    begin
        if (probe_en)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}},
                       out_reg.link_up, out_reg.frame_ready,
                       out_reg.channel_count, out_reg.channel_value};

    a_edge_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_op_reg == OP_EDGE) |-> advance)
        else $error("edge transaction stalled");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_time_reg)
                                        && $stable(in_sel_reg)))
        else $error("stalled input register lost its transaction");

    a_probe_result: assert property (@(posedge clk) disable iff (!rst_n)
        probe_en |=> out_valid_reg)
        else $error("probe produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !probe_en)
        else $error("result register overwritten while held");

endmodule
